/* sv/srsm_pkg.sv */
package srsm_pkg;

   localparam int MAX_SLOTS  = 1024;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 3;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FETCH = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_ALLOC   = 2'd1;
   localparam logic [1:0] ST_READY   = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   localparam logic [2:0] RC_OK       = 3'd0;
   localparam logic [2:0] RC_BAD_IDX  = 3'd1;
   localparam logic [2:0] RC_FULL     = 3'd2;
   localparam logic [2:0] RC_NO_EMPTY = 3'd3;
   localparam logic [2:0] RC_EMPTY    = 3'd4;
   localparam logic [2:0] RC_NO_READY = 3'd5;

endpackage

/* sv/slot_ring_status_manager_top.sv */
// flow: set status writes its slot on acceptance, then done; allocate and fetch go through
// check and eval to done; rejects (bad index, full, empty) go from check to done; fetch goes
// back to check per invalid slot skipped (at most MAX_TRIES); clear walks every slot to done;
// throughput: one command at a time through the shared index unit and the slot memory
// the next command is taken the cycle after done loads the result into a free output register
// reset: synchronous, then a clearing pass over every slot of the slot memory with req_tready low
module slot_ring_status_manager_top #(
   parameter int MAX_TRIES = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // target_slot[9:0], new_status[11:10], zero pad
   input  logic [srsm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[1:0]
   input  logic [srsm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // granted_slot[9:0], occupancy[20:10], ring_empty[21], zero pad
   output logic [srsm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result_code[2:0]
   output logic [srsm_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srsm_pkg::CNT_W-1:0]        csr_data
);
   import srsm_pkg::*;

   localparam int TRY_W = $clog2(MAX_TRIES + 1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_CHECK, S_EVAL, S_CLEAR, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   slot_count_ff;
   logic [IDX_W-1:0]   ri_ff, ri_in, wi_ff, wi_in;
   logic               empty_ff, empty_in;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [TRY_W-1:0]   tries_ff, tries_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [2:0]         code_ff, code_in;
   logic [IDX_W-1:0]   grant_ff, grant_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_code_ff, rsp_code_in;
   logic [IDX_W-1:0]   rsp_grant_ff, rsp_grant_in;
   logic [CNT_W-1:0]   rsp_occ_ff, rsp_occ_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic [1:0]         slot_mem [MAX_SLOTS];
   logic [1:0]         rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [1:0]         mem_wdata;

   logic [CNT_W-1:0]   size;
   logic               idx_ok;
   logic [IDX_W-1:0]   at_sel, next_idx;
   logic [CNT_W-1:0]   at_inc, idx_diff, occ;
   logic [TRY_W-1:0]   tries_inc;
   logic               req_acc;

   assign size = (slot_count_ff == '0) ? CNT_W'(1) :
                 (slot_count_ff > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_ff;
   assign idx_ok = ({1'b0, ri_ff} < size) && ({1'b0, wi_ff} < size);

   // shared index unit
   assign at_sel   = (cmd_ff == CMD_ALLOC) ? wi_ff : ri_ff;
   assign at_inc   = {1'b0, at_sel} + CNT_W'(1);
   assign next_idx = (at_inc == size) ? '0 : at_inc[IDX_W-1:0];

   assign idx_diff = {1'b0, wi_ff} - {1'b0, ri_ff};
   assign occ = (!idx_ok || empty_ff) ? '0 : (wi_ff > ri_ff) ? idx_diff : size + idx_diff;

   assign tries_inc = tries_ff + TRY_W'(1);
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign mem_raddr  = at_sel;

   always_comb begin
      state_in     = state_ff;
      ri_in        = ri_ff;
      wi_in        = wi_ff;
      empty_in     = empty_ff;
      clr_cnt_in   = clr_cnt_ff;
      tries_in     = tries_ff;
      cmd_in       = cmd_ff;
      code_in      = code_ff;
      grant_in     = grant_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_empty_in = rsp_empty_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_cnt_ff;
      mem_wdata    = ST_EMPTY;
      case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(MAX_SLOTS - 1)) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               cmd_in   = req_tuser;
               code_in  = RC_OK;
               grant_in = '0;
               tries_in = '0;
               case (req_tuser)
                  CMD_ALLOC, CMD_FETCH: state_in = S_CHECK;
                  CMD_SET: begin
                     mem_we    = 1'b1;
                     mem_waddr = req_tdata[IDX_W-1:0];
                     mem_wdata = req_tdata[IDX_W+1:IDX_W];
                     state_in  = S_DONE;
                  end
                  default: begin
                     ri_in      = '0;
                     wi_in      = '0;
                     empty_in   = 1'b1;
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (!idx_ok) begin
               code_in  = RC_BAD_IDX;
               state_in = S_DONE;
            end else if (ri_ff == wi_ff && (cmd_ff == CMD_ALLOC) == !empty_ff) begin
               code_in  = (cmd_ff == CMD_ALLOC) ? RC_FULL : RC_EMPTY;
               state_in = S_DONE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (cmd_ff == CMD_ALLOC) begin
               if (rd_data_ff != ST_EMPTY) begin
                  code_in = RC_NO_EMPTY;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = wi_ff;
                  mem_wdata = ST_ALLOC;
                  wi_in     = next_idx;
                  empty_in  = 1'b0;
                  grant_in  = wi_ff;
               end
            end else if (rd_data_ff == ST_READY) begin
               ri_in    = next_idx;
               empty_in = (next_idx == wi_ff);
               grant_in = ri_ff;
            end else if (rd_data_ff == ST_INVALID) begin
               mem_we    = 1'b1;
               mem_waddr = ri_ff;
               ri_in     = next_idx;
               empty_in  = (next_idx == wi_ff);
               tries_in  = tries_inc;
               if (tries_inc == TRY_W'(MAX_TRIES)) begin
                  code_in = RC_NO_READY;
               end else begin
                  state_in = S_CHECK;
               end
            end else begin
               code_in = RC_NO_READY;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_grant_in = (code_ff == RC_OK) ? grant_ff : '0;
               rsp_occ_in   = occ;
               rsp_empty_in = empty_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         slot_count_ff <= CNT_W'(MAX_SLOTS);
         ri_ff         <= '0;
         wi_ff         <= '0;
         empty_ff      <= 1'b1;
         clr_cnt_ff    <= '0;
         tries_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ri_ff        <= ri_in;
         wi_ff        <= wi_in;
         empty_ff     <= empty_in;
         clr_cnt_ff   <= clr_cnt_in;
         tries_ff     <= tries_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            slot_count_ff <= csr_data;
         end
      end
      cmd_ff       <= cmd_in;
      code_ff      <= code_in;
      grant_ff     <= grant_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_code_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - IDX_W - CNT_W - 1){1'b0}},
                        rsp_empty_ff, rsp_occ_ff, rsp_grant_ff};

endmodule

/* sv/srsm_checker.sv */
module srsm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [srsm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic [srsm_pkg::REQ_USER_W-1:0]   req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [srsm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [srsm_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [srsm_pkg::CNT_W-1:0]        csr_data
);
   import srsm_pkg::*;

   // stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // only ok grants a slot
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RC_OK |-> rsp_tdata[IDX_W-1:0] == '0)
      else $error("slot granted with error code");

   // an empty ring reports no occupied slots
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[IDX_W+CNT_W] |-> rsp_tdata[IDX_W+CNT_W-1:IDX_W] == '0)
      else $error("empty ring with non-zero occupancy");

   // request side closed and no result valid as reset falls into the clearing pass
   a_init_closed: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready && !rsp_tvalid)
      else $error("request taken during clearing pass");

endmodule

bind slot_ring_status_manager_top srsm_checker u_srsm_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import srsm_pkg::*;

   localparam int FETCH_TRIES = 10;
   localparam int IDLE_PCT    = 31;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 60;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [IDX_W-1:0] slot;
      logic [1:0]       status;
   } ring_cmd_type;

   typedef struct packed {
      logic [2:0]       code;
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] occ;
      logic             empty;
   } ring_reply_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data   = '0;

   // ring state as the block should hold it
   logic [CNT_W-1:0] size_reg;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic             ring_is_empty;
   logic [1:0]       slot_tag [MAX_SLOTS];

   ring_cmd_type   cmd_backlog [$];
   ring_reply_type replies_due [$];
   ring_cmd_type   next_cmd;
   ring_reply_type want;
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          hold_left      = 0;
   bit          no_idle        = 1'b0;
   bit          hold_wanted    = 1'b0;
   bit          hold_taken     = 1'b0;

   slot_ring_status_manager_top #(
      .MAX_TRIES(FETCH_TRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CNT_W-1:0] ring_span(logic [CNT_W-1:0] reg_val);
      if (reg_val == 0) return CNT_W'(1);
      if (reg_val > MAX_SLOTS) return CNT_W'(MAX_SLOTS);
      return reg_val;
   endfunction

   function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] at,
                                                  logic [CNT_W-1:0] span);
      return IDX_W'(({1'b0, at} + 1) % span);
   endfunction

   function automatic void ring_wipe();
      foreach (slot_tag[i]) slot_tag[i] = ST_EMPTY;
      rd_idx        = '0;
      wr_idx        = '0;
      ring_is_empty = 1'b1;
   endfunction

   function automatic ring_reply_type ring_apply(ring_cmd_type c);
      ring_reply_type   r;
      logic [CNT_W-1:0] span;
      logic [IDX_W-1:0] nxt;
      logic             idx_ok;
      bit               done;
      int               tries;
      span   = ring_span(size_reg);
      r      = '0;
      idx_ok = (rd_idx < span) && (wr_idx < span);
      case (c.cmd)
         CMD_ALLOC: begin
            if (!idx_ok) begin
               r.code = RC_BAD_IDX;
            end else if (rd_idx == wr_idx && !ring_is_empty) begin
               r.code = RC_FULL;
            end else if (slot_tag[wr_idx] != ST_EMPTY) begin
               r.code = RC_NO_EMPTY;
            end else begin
               r.slot           = wr_idx;
               slot_tag[wr_idx] = ST_ALLOC;
               wr_idx           = ring_next(wr_idx, span);
               ring_is_empty    = 1'b0;
            end
         end
         CMD_FETCH: begin
            r.code = RC_NO_READY;
            done   = 1'b0;
            for (tries = 0; tries < FETCH_TRIES && !done; tries++) begin
               if (!idx_ok) begin
                  r.code = RC_BAD_IDX;
                  done   = 1'b1;
               end else if (rd_idx == wr_idx && ring_is_empty) begin
                  r.code = RC_EMPTY;
                  done   = 1'b1;
               end else begin
                  nxt = ring_next(rd_idx, span);
                  if (slot_tag[rd_idx] == ST_READY) begin
                     r.code        = RC_OK;
                     r.slot        = rd_idx;
                     done          = 1'b1;
                     rd_idx        = nxt;
                     ring_is_empty = (nxt == wr_idx);
                  end else if (slot_tag[rd_idx] == ST_INVALID) begin
                     slot_tag[rd_idx] = ST_EMPTY;
                     rd_idx           = nxt;
                     ring_is_empty    = (nxt == wr_idx);
                  end
               end
            end
         end
         CMD_SET: begin
            slot_tag[c.slot] = c.status;
         end
         default: begin
            ring_wipe();
         end
      endcase
      idx_ok = (rd_idx < span) && (wr_idx < span);
      if (!idx_ok || ring_is_empty) begin
         r.occ = '0;
      end else if (wr_idx > rd_idx) begin
         r.occ = {1'b0, wr_idx} - {1'b0, rd_idx};
      end else begin
         r.occ = span - ({1'b0, rd_idx} - {1'b0, wr_idx});
      end
      r.empty = ring_is_empty;
      return r;
   endfunction

   task automatic note_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned exp_val);
      if (got != exp_val) begin
         note_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            replies_due.push_back(ring_apply(ring_cmd_type'({req_tuser,
                                                             req_tdata[IDX_W-1:0],
                                                             req_tdata[IDX_W +: 2]})));
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               next_cmd = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W - IDX_W - 2){1'b0}}, next_cmd.status, next_cmd.slot};
               req_tuser  <= next_cmd.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver readiness, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_wanted && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            note_mismatch("result transaction with none outstanding");
         end else begin
            want = replies_due.pop_front();
            check_field("result_code", rsp_tuser[2:0], want.code);
            check_field("granted_slot", rsp_tdata[IDX_W-1:0], want.slot);
            check_field("occupancy", rsp_tdata[IDX_W +: CNT_W], want.occ);
            check_field("ring_empty", rsp_tdata[IDX_W + CNT_W], want.empty);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic wait_quiet();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_tvalid || replies_due.size() != 0);
   endtask

   task automatic write_slot_count(logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = value;
      @(negedge clock);
   endtask

   task automatic queue_item(logic [1:0] cmd, int slot, logic [1:0] status);
      ring_cmd_type c;
      c.cmd    = cmd;
      c.slot   = IDX_W'(slot);
      c.status = status;
      cmd_backlog.push_back(c);
   endtask

   // random commands, with set status mostly aimed at recently allocated slots
   task automatic queue_random(int count);
      logic [CNT_W-1:0] span;
      int               guess;
      int               pick;
      int               n;
      ring_cmd_type     c;
      span  = ring_span(size_reg);
      guess = wr_idx % span;
      for (n = 0; n < count; n++) begin
         c.slot   = IDX_W'($urandom_range(MAX_SLOTS - 1));
         c.status = 2'($urandom_range(3));
         pick     = $urandom_range(99);
         if (pick < 3) begin
            c.cmd = CMD_CLEAR;
            guess = 0;
         end else if (pick < 38) begin
            c.cmd = CMD_ALLOC;
            guess = (guess + 1) % span;
         end else if (pick < 68) begin
            c.cmd = CMD_FETCH;
         end else begin
            c.cmd = CMD_SET;
            if ($urandom_range(9) != 0) begin
               c.slot = IDX_W'((guess + 4 * span - 1 - $urandom_range(3)) % span);
            end
            pick     = $urandom_range(99);
            c.status = pick < 45 ? ST_READY : pick < 75 ? ST_INVALID :
                       pick < 88 ? ST_ALLOC : ST_EMPTY;
         end
         cmd_backlog.push_back(c);
      end
   endtask

   task automatic run_phase(logic [CNT_W-1:0] size_val, int count);
      write_slot_count(size_val);
      queue_random(count);
      wait_quiet();
   endtask

   initial begin
      int n;
      size_reg = CNT_W'(MAX_SLOTS);
      ring_wipe();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_item(CMD_FETCH, 0, ST_EMPTY);
      queue_item(CMD_SET, MAX_SLOTS - 1, ST_INVALID);
      repeat (11) queue_item(CMD_ALLOC, 0, ST_EMPTY);
      for (n = 0; n < 11; n++) queue_item(CMD_SET, n, ST_INVALID);
      // gives up after the try limit, then drains the ring by skipping
      queue_item(CMD_FETCH, 0, ST_EMPTY);
      queue_item(CMD_FETCH, 0, ST_EMPTY);
      wait_quiet();

      // indices left beyond the shrunken ring until a clear
      run_phase(CNT_W'(0), 150);
      no_idle = 1'b1;
      run_phase(CNT_W'(2047), 250);
      no_idle = 1'b0;
      run_phase(CNT_W'(1), 150);
      hold_wanted = 1'b1;
      run_phase(CNT_W'(4), 300);
      run_phase(CNT_W'(12), 400);
      run_phase(CNT_W'(MAX_SLOTS), 200);
      run_phase(CNT_W'(2), 150);
      run_phase(CNT_W'($urandom_range(40, 3)), 350);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
